// ----- sv/efcd_pkg.sv -----
// Shared types and constants for the escape-framed command deframer.
package efcd_pkg;

    localparam int LENGTH_BITS = 24;
    localparam int CNT_W       = LENGTH_BITS + 1;

    localparam logic [3:0]  INTRO_LEN    = 4'd4;
    localparam logic [3:0]  HEADER_BYTES = 4'd8;
    localparam logic [CNT_W-1:0] TAIL_BYTES = CNT_W'(4);

    localparam logic [7:0]  ESC_BYTE     = 8'h1B;
    localparam logic [7:0]  BACKSPACE    = 8'h08;
    localparam logic [31:0] TRAILER_WORD = 32'h4253_542E;

    localparam logic [7:0] INTRO_SEQ [4] = '{8'h1B, 8'h5B, 8'h57, 8'h5D};

    typedef enum logic [2:0] {
        REG_ENABLE        = 3'd0,
        REG_COMMAND_LIMIT = 3'd1,
        REG_MAX_LENGTH    = 3'd2,
        REG_TIMEOUT_TICKS = 3'd3,
        REG_MIN_PROGRESS  = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        CAUSE_NONE = 2'd0,
        CAUSE_CMD  = 2'd1,
        CAUSE_LONG = 2'd2,
        CAUSE_TIME = 2'd3
    } cause_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_HEAD = 3'b010,
        PH_RECV = 3'b100
    } phase_t;

    typedef struct packed {
        logic              enable;
        logic [7:0]        command_limit;
        logic [CNT_W-1:0]  max_length;
        logic [15:0]       timeout_ticks;
        logic [15:0]       min_progress;
    } cfg_t;

    typedef struct packed {
        logic                   pass_through;
        logic [7:0]             out_byte;
        logic                   payload_valid;
        logic                   is_tail;
        logic                   frame_done;
        logic                   tail_ok;
        logic [7:0]             command_code;
        logic [LENGTH_BITS-1:0] body_length;
        logic                   aborted;
        cause_t                 abort_cause;
    } result_t;

endpackage

// ----- sv/escape_framed_command_deframer.sv -----
// Top level of the escape-framed command deframer: input stage, parser, result stage.
//
//  channel   | direction | request carries
//  ----------+-----------+-------------------------------------------------
//  s_*       | in        | one received byte or one watchdog tick
//  m_*       | out       | byte disposition, payload flags, frame summary
//  cfg_*     | in        | register index and write data
//
//  One request per cycle sustained while the output is not stalled.
//  The input register feeds the parser logic, whose result lands in the output register.
//  A stalled output holds the parser and the input stage; ticks that do not abort give
//  no output request. Reset clears the parser to idle and loads register defaults.
//  A write to the enable register also clears the parser.
module escape_framed_command_deframer
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] action

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // [7:0] out_byte, [8] tail_ok, [16:9] command_code,
                                    // [40:17] body_length, [41] aborted,
                                    // [43:42] abort_cause, [47:44] zero
    output logic [2:0]   m_tuser,   // [0] pass_through, [1] payload_valid, [2] is_tail
    output logic         m_tlast,   // frame_done

    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [24:0]  cfg_data
);
    import efcd_pkg::*;

    cfg_t        cfg;
    logic        parser_clear;
    logic        in_vld_reg;
    logic        in_act_reg;
    logic [7:0]  in_byte_reg;
    logic        proc;
    logic        res_valid;
    result_t     res;
    logic        out_vld_reg;
    result_t     out_reg;

    assign cfg_ready = 1'b1;

    efcd_cfg_regs u_cfg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (cfg_valid && cfg_ready),
        .wr_index     (cfg_index),
        .wr_data      (cfg_data),
        .cfg          (cfg),
        .parser_clear (parser_clear)
    );

    assign proc     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_act_reg  <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    efcd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .clear     (parser_clear),
        .step      (proc),
        .action    (in_act_reg),
        .data_byte (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (proc)
        begin
            out_vld_reg <= res_valid;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'd0, out_reg.abort_cause, out_reg.aborted, out_reg.body_length,
                       out_reg.command_code, out_reg.tail_ok, out_reg.out_byte};
    assign m_tuser  = {out_reg.is_tail, out_reg.payload_valid, out_reg.pass_through};
    assign m_tlast  = out_reg.frame_done;

    a_done_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tuser[1] && m_tuser[2] && !m_tuser[0]))
        else $error("frame end without a tail payload byte");

    a_cause_matches_abort: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_reg.aborted == (out_reg.abort_cause != CAUSE_NONE)))
        else $error("abort flag and cause disagree");

    a_pass_not_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && (m_tuser[1] || out_reg.aborted)))
        else $error("pass-through byte marked as frame traffic");

    a_stall_holds_parser: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && out_vld_reg && !m_tready) |=> (in_vld_reg && out_vld_reg))
        else $error("input stage moved while output stalled");

endmodule

// ----- sv/efcd_cfg_regs.sv -----
// Configuration register bank; a write to the enable register triggers a parser clear.
module efcd_cfg_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [2:0]          wr_index,
    input  logic [24:0]         wr_data,
    output efcd_pkg::cfg_t      cfg,
    output logic                parser_clear
);
    import efcd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable        <= 1'b0;
            cfg_reg.command_limit <= 8'd16;
            cfg_reg.max_length    <= CNT_W'(1048575);
            cfg_reg.timeout_ticks <= 16'd2000;
            cfg_reg.min_progress  <= 16'd50;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_ENABLE:        cfg_reg.enable        <= wr_data[0];
                REG_COMMAND_LIMIT: cfg_reg.command_limit <= wr_data[7:0];
                REG_MAX_LENGTH:    cfg_reg.max_length    <= wr_data;
                REG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= wr_data[15:0];
                REG_MIN_PROGRESS:  cfg_reg.min_progress  <= wr_data[15:0];
                default:           ;
            endcase
        end
    end

    assign cfg          = cfg_reg;
    assign parser_clear = wr_en && (wr_index == REG_ENABLE);

endmodule

// ----- sv/efcd_parser.sv -----
// Frame parser state and per-item next-state and result logic.
module efcd_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  efcd_pkg::cfg_t      cfg,
    input  logic                clear,
    input  logic                step,
    input  logic                action,
    input  logic [7:0]          data_byte,
    output logic                res_valid,
    output efcd_pkg::result_t   res
);
    import efcd_pkg::*;

    phase_t            phase_reg,    phase_next;
    logic [3:0]        hdr_cnt_reg,  hdr_cnt_next;
    logic [7:0]        cmd_reg,      cmd_next;
    logic [CNT_W-1:0]  len_reg,      len_next;
    logic [CNT_W-1:0]  rcv_cnt_reg,  rcv_cnt_next;
    logic [CNT_W-1:0]  mark_reg,     mark_next;
    logic [1:0]        ext_cnt_reg,  ext_cnt_next;
    logic [15:0]       tick_cnt_reg, tick_cnt_next;
    logic [31:0]       tail_win_reg, tail_win_next;

    logic              drop_frame;
    logic              restart_esc;
    logic [16:0]       tick_inc;
    logic [CNT_W-1:0]  progress;
    logic [23:0]       len_acc;
    logic [CNT_W-1:0]  len_total;
    logic [CNT_W-1:0]  rcv_inc;
    logic [31:0]       tail_shift;

    assign tick_inc   = {1'b0, tick_cnt_reg} + 17'd1;
    assign progress   = rcv_cnt_reg - mark_reg;
    assign len_acc    = {len_reg[15:0], data_byte};
    assign len_total  = {1'b0, len_acc} + TAIL_BYTES;
    assign rcv_inc    = rcv_cnt_reg + CNT_W'(1);
    assign tail_shift = {tail_win_reg[23:0], data_byte};

    always_comb
    begin
        phase_next    = phase_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        cmd_next      = cmd_reg;
        len_next      = len_reg;
        rcv_cnt_next  = rcv_cnt_reg;
        mark_next     = mark_reg;
        ext_cnt_next  = ext_cnt_reg;
        tick_cnt_next = tick_cnt_reg;
        tail_win_next = tail_win_reg;
        drop_frame    = 1'b0;
        restart_esc   = 1'b0;
        res_valid     = 1'b0;
        res           = '0;

        if (action)
        begin
            if (cfg.enable && phase_reg == PH_RECV)
            begin
                if (tick_inc < {1'b0, cfg.timeout_ticks})
                begin
                    tick_cnt_next = tick_inc[15:0];
                end
                else if (progress < {9'd0, cfg.min_progress} || ext_cnt_reg[1])
                begin
                    res_valid        = 1'b1;
                    res.command_code = cmd_reg;
                    res.aborted      = 1'b1;
                    res.abort_cause  = CAUSE_TIME;
                    drop_frame       = 1'b1;
                end
                else
                begin
                    mark_next     = rcv_cnt_reg;
                    tick_cnt_next = '0;
                    ext_cnt_next  = ext_cnt_reg + 2'd1;
                end
            end
        end
        else
        begin
            res_valid    = 1'b1;
            res.out_byte = data_byte;
            if (!cfg.enable)
            begin
                res.pass_through = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        if (data_byte == ESC_BYTE)
                        begin
                            phase_next   = PH_HEAD;
                            hdr_cnt_next = 4'd1;
                        end
                        else
                        begin
                            res.pass_through = 1'b1;
                        end
                    end
                    PH_HEAD:
                    begin
                        if (hdr_cnt_reg < INTRO_LEN)
                        begin
                            if (data_byte == BACKSPACE)
                            begin
                                hdr_cnt_next = hdr_cnt_reg - 4'd1;
                                drop_frame   = (hdr_cnt_reg == 4'd1);
                            end
                            else if (data_byte == INTRO_SEQ[hdr_cnt_reg[1:0]])
                            begin
                                hdr_cnt_next = hdr_cnt_reg + 4'd1;
                            end
                            else
                            begin
                                drop_frame       = 1'b1;
                                restart_esc      = (data_byte == ESC_BYTE);
                                res.pass_through = (data_byte != ESC_BYTE);
                            end
                        end
                        else if (data_byte >= cfg.command_limit)
                        begin
                            res.command_code = data_byte;
                            res.aborted      = 1'b1;
                            res.abort_cause  = CAUSE_CMD;
                            drop_frame       = 1'b1;
                            restart_esc      = (data_byte == ESC_BYTE);
                        end
                        else
                        begin
                            cmd_next         = data_byte;
                            phase_next       = PH_RECV;
                            hdr_cnt_next     = INTRO_LEN + 4'd1;
                            len_next         = '0;
                            rcv_cnt_next     = '0;
                            mark_next        = '0;
                            tick_cnt_next    = '0;
                            ext_cnt_next     = 2'd1;
                            tail_win_next    = '0;
                            res.command_code = data_byte;
                        end
                    end
                    PH_RECV:
                    begin
                        res.command_code = cmd_reg;
                        if (hdr_cnt_reg < HEADER_BYTES)
                        begin
                            hdr_cnt_next = hdr_cnt_reg + 4'd1;
                            if (hdr_cnt_reg == HEADER_BYTES - 4'd1)
                            begin
                                len_next = len_total;
                                if (len_total > cfg.max_length)
                                begin
                                    res.aborted     = 1'b1;
                                    res.abort_cause = CAUSE_LONG;
                                    drop_frame      = 1'b1;
                                end
                            end
                            else
                            begin
                                len_next = {1'b0, len_acc};
                            end
                        end
                        else
                        begin
                            res.payload_valid = 1'b1;
                            res.is_tail = ({1'b0, rcv_cnt_reg} + {1'b0, TAIL_BYTES})
                                          >= {1'b0, len_reg};
                            tail_win_next = tail_shift;
                            rcv_cnt_next  = rcv_inc;
                            if (rcv_inc >= len_reg)
                            begin
                                res.frame_done  = 1'b1;
                                res.tail_ok     = (tail_shift == TRAILER_WORD);
                                res.body_length = LENGTH_BITS'(len_reg - TAIL_BYTES);
                                drop_frame      = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        drop_frame = 1'b1;
                    end
                endcase
            end
        end

        if (drop_frame)
        begin
            phase_next    = PH_IDLE;
            hdr_cnt_next  = '0;
            cmd_next      = '0;
            len_next      = '0;
            rcv_cnt_next  = '0;
            mark_next     = '0;
            ext_cnt_next  = '0;
            tick_cnt_next = '0;
            tail_win_next = '0;
        end
        if (restart_esc)
        begin
            phase_next   = PH_HEAD;
            hdr_cnt_next = 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            hdr_cnt_reg  <= '0;
            cmd_reg      <= '0;
            len_reg      <= '0;
            rcv_cnt_reg  <= '0;
            mark_reg     <= '0;
            ext_cnt_reg  <= '0;
            tick_cnt_reg <= '0;
            tail_win_reg <= '0;
        end
        else if (clear)
        begin
            phase_reg    <= PH_IDLE;
            hdr_cnt_reg  <= '0;
            cmd_reg      <= '0;
            len_reg      <= '0;
            rcv_cnt_reg  <= '0;
            mark_reg     <= '0;
            ext_cnt_reg  <= '0;
            tick_cnt_reg <= '0;
            tail_win_reg <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            cmd_reg      <= cmd_next;
            len_reg      <= len_next;
            rcv_cnt_reg  <= rcv_cnt_next;
            mark_reg     <= mark_next;
            ext_cnt_reg  <= ext_cnt_next;
            tick_cnt_reg <= tick_cnt_next;
            tail_win_reg <= tail_win_next;
        end
    end

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the escape-framed command deframer.
`timescale 1ns / 100ps

module tb_top;

    import efcd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic       tick;
        logic [7:0] data;
    } term_item_t;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata   = 8'h00;
    logic         s_tuser   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [47:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = 3'd0;
    logic [24:0]  cfg_data  = 25'd0;

    escape_framed_command_deframer i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    term_item_t rx_stream [$];
    result_t    deframed_q [$];
    term_item_t in_flight;
    bit         took;
    int         mismatches;
    int         cycles;
    int         queued_items;
    int         src_rate;
    int         snk_rate;
    int         src_gap;
    int         snk_gap;
    bit         no_idle;

    int         gen_lim;
    int         gen_max;
    int         gen_tmo;

    cfg_t         regs;
    phase_t       st_phase;
    logic [3:0]   hdr_cnt;
    logic [7:0]   cur_cmd;
    logic [24:0]  frame_len;
    logic [24:0]  rx_cnt;
    logic [24:0]  prog_mark;
    logic [1:0]   ext_cnt;
    logic [15:0]  tick_cnt;
    logic [31:0]  tail_bytes;

    task automatic drop_frame();
        st_phase   = PH_IDLE;
        hdr_cnt    = 4'd0;
        cur_cmd    = 8'h00;
        frame_len  = '0;
        rx_cnt     = '0;
        prog_mark  = '0;
        ext_cnt    = 2'd0;
        tick_cnt   = 16'd0;
        tail_bytes = 32'd0;
    endtask

    task automatic resync_on(input logic [7:0] c);
        drop_frame();
        if (c == ESC_BYTE)
        begin
            st_phase = PH_HEAD;
            hdr_cnt  = 4'd1;
        end
    endtask

    task automatic deframe_step(input logic is_tick, input logic [7:0] c,
                                output bit emit, output result_t r);
        logic [16:0] t;
        r    = '0;
        emit = 1'b0;
        if (is_tick)
        begin
            if (!regs.enable || st_phase != PH_RECV)
                return;
            t = {1'b0, tick_cnt} + 17'd1;
            if (t < {1'b0, regs.timeout_ticks})
            begin
                tick_cnt = t[15:0];
                return;
            end
            if ((rx_cnt - prog_mark) < regs.min_progress || ext_cnt >= 2'd2)
            begin
                r.command_code = cur_cmd;
                r.aborted      = 1'b1;
                r.abort_cause  = CAUSE_TIME;
                drop_frame();
                emit = 1'b1;
                return;
            end
            prog_mark = rx_cnt;
            tick_cnt  = 16'd0;
            ext_cnt   = ext_cnt + 2'd1;
            return;
        end
        emit       = 1'b1;
        r.out_byte = c;
        if (!regs.enable)
        begin
            r.pass_through = 1'b1;
            return;
        end
        case (st_phase)
            PH_IDLE:
            begin
                if (c == ESC_BYTE)
                begin
                    st_phase = PH_HEAD;
                    hdr_cnt  = 4'd1;
                end
                else
                    r.pass_through = 1'b1;
            end
            PH_HEAD:
            begin
                if (hdr_cnt < INTRO_LEN)
                begin
                    if (c == BACKSPACE)
                    begin
                        hdr_cnt = hdr_cnt - 4'd1;
                        if (hdr_cnt == 4'd0)
                            drop_frame();
                    end
                    else if (c == INTRO_SEQ[hdr_cnt[1:0]])
                        hdr_cnt = hdr_cnt + 4'd1;
                    else
                    begin
                        resync_on(c);
                        r.pass_through = (st_phase == PH_IDLE);
                    end
                end
                else if (c >= regs.command_limit)
                begin
                    r.command_code = c;
                    r.aborted      = 1'b1;
                    r.abort_cause  = CAUSE_CMD;
                    resync_on(c);
                end
                else
                begin
                    cur_cmd        = c;
                    st_phase       = PH_RECV;
                    hdr_cnt        = INTRO_LEN + 4'd1;
                    frame_len      = '0;
                    rx_cnt         = '0;
                    prog_mark      = '0;
                    tick_cnt       = 16'd0;
                    ext_cnt        = 2'd1;
                    tail_bytes     = 32'd0;
                    r.command_code = c;
                end
            end
            default:
            begin
                r.command_code = cur_cmd;
                if (hdr_cnt < HEADER_BYTES)
                begin
                    frame_len = {1'b0, frame_len[15:0], c};
                    hdr_cnt   = hdr_cnt + 4'd1;
                    if (hdr_cnt == HEADER_BYTES)
                    begin
                        frame_len = frame_len + TAIL_BYTES;
                        if (frame_len > regs.max_length)
                        begin
                            r.aborted     = 1'b1;
                            r.abort_cause = CAUSE_LONG;
                            drop_frame();
                        end
                    end
                end
                else
                begin
                    r.payload_valid = 1'b1;
                    r.is_tail       = (rx_cnt + TAIL_BYTES >= frame_len);
                    tail_bytes      = {tail_bytes[23:0], c};
                    rx_cnt          = rx_cnt + 25'd1;
                    if (rx_cnt >= frame_len)
                    begin
                        r.frame_done  = 1'b1;
                        r.tail_ok     = (tail_bytes == TRAILER_WORD);
                        r.body_length = LENGTH_BITS'(frame_len - TAIL_BYTES);
                        drop_frame();
                    end
                end
            end
        endcase
    endtask

    function automatic string show(input result_t r);
        return $sformatf({"pt=%0b byte=%02h pv=%0b tail=%0b done=%0b ok=%0b ",
                          "cmd=%02h len=%06h ab=%0b cause=%0d"},
                         r.pass_through, r.out_byte, r.payload_valid, r.is_tail,
                         r.frame_done, r.tail_ok, r.command_code, r.body_length,
                         r.aborted, r.abort_cause);
    endfunction

    always @(posedge clk)
    begin : accept_p
        bit      emit;
        result_t r;
        took = rst_n && s_tvalid && s_tready;
        if (took)
        begin
            deframe_step(in_flight.tick, in_flight.data, emit, r);
            if (emit)
                deframed_q.push_back(r);
        end
    end

    always @(negedge clk)
    begin : driver_p
        if (rst_n && !(s_tvalid && !took))
        begin
            if (src_gap == 0 && !no_idle && src_rate != 0 && $urandom_range(1, 16) <= src_rate)
                src_gap = $urandom_range(1, 4);
            if (src_gap != 0 || rx_stream.size() == 0)
            begin
                s_tvalid <= 1'b0;
                if (src_gap != 0)
                    src_gap = src_gap - 1;
            end
            else
            begin
                in_flight = rx_stream.pop_front();
                s_tvalid  <= 1'b1;
                s_tuser   <= in_flight.tick;
                s_tdata   <= in_flight.data;
            end
        end
    end

    always @(negedge clk)
    begin : sink_p
        if (snk_gap == 0 && !no_idle && snk_rate != 0 && $urandom_range(1, 16) <= snk_rate)
            snk_gap = $urandom_range(1, 4);
        if (snk_gap != 0)
        begin
            m_tready <= 1'b0;
            snk_gap = snk_gap - 1;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : monitor_p
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.pass_through  = m_tuser[0];
            got.out_byte      = m_tdata[7:0];
            got.payload_valid = m_tuser[1];
            got.is_tail       = m_tuser[2];
            got.frame_done    = m_tlast;
            got.tail_ok       = m_tdata[8];
            got.command_code  = m_tdata[16:9];
            got.body_length   = m_tdata[40:17];
            got.aborted       = m_tdata[41];
            got.abort_cause   = cause_t'(m_tdata[43:42]);
            if (deframed_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected output: %s", show(got));
                mismatches++;
            end
            else
            begin
                want = deframed_q.pop_front();
                if (got !== want)
                begin
                    if (mismatches < 10)
                        $display("mismatch: expected %s\n          actual   %s",
                                 show(want), show(got));
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog_p
        cycles++;
        if (cycles % 64 == 0)
        begin
            src_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
            snk_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic put_byte(input logic [7:0] c);
        rx_stream.push_back('{tick: 1'b0, data: c});
        queued_items++;
    endtask

    task automatic put_tick();
        rx_stream.push_back('{tick: 1'b1, data: 8'($urandom_range(0, 255))});
        queued_items++;
    endtask

    task automatic put_frame(input bit force_big);
        int          body;
        int          flen;
        int          n_sent;
        int          k;
        int          bs_at;
        logic [7:0]  cmd;
        logic [31:0] tail;
        bs_at = $urandom_range(0, 7);
        for (k = 0; k < 4; k++)
        begin
            put_byte(INTRO_SEQ[k]);
            if (k < 3 && k + 1 == bs_at)
            begin
                put_byte(BACKSPACE);
                put_byte(INTRO_SEQ[k]);
            end
        end
        case ($urandom_range(0, 9))
            0:       cmd = ESC_BYTE;
            1:       cmd = 8'($urandom_range(0, 255));
            default: cmd = 8'($urandom_range(0, gen_lim - 1));
        endcase
        if (force_big)
            cmd = 8'h00;
        put_byte(cmd);
        if (cmd >= gen_lim)
            return;
        if (force_big)
            body = 24'hFF_FFFF;
        else if ($urandom_range(0, 9) == 0)
            body = $urandom_range(0, 24'hFF_FFFF);
        else
            body = $urandom_range(0, 12);
        flen = body + 4;
        if (flen <= gen_max && flen > 48 && gen_tmo > 16)
        begin
            body = $urandom_range(0, 12);
            flen = body + 4;
        end
        put_byte(body[23:16]);
        put_byte(body[15:8]);
        put_byte(body[7:0]);
        if (flen > gen_max)
            return;
        if ($urandom_range(0, 3) == 0)
            tail = TRAILER_WORD ^ (32'd1 << $urandom_range(0, 31));
        else
            tail = TRAILER_WORD;
        if (gen_tmo <= 16 && (flen > 48 || $urandom_range(0, 7) == 0))
            n_sent = $urandom_range(0, (flen > 20) ? 20 : flen - 1);
        else
            n_sent = flen;
        for (k = 0; k < n_sent; k++)
        begin
            if ($urandom_range(0, 11) == 0)
                put_tick();
            if (k < flen - 4)
                put_byte(8'($urandom_range(0, 255)));
            else
                put_byte(tail[8 * (flen - 1 - k) +: 8]);
        end
        if (n_sent < flen)
            repeat (2 * ((gen_tmo < 1) ? 1 : gen_tmo) + 2)
                put_tick();
    endtask

    task automatic put_noise();
        int         k;
        int         i;
        logic [7:0] b;
        case ($urandom_range(0, 5))
            0: put_tick();
            1: put_byte(BACKSPACE);
            2: put_byte(ESC_BYTE);
            3:
            begin
                k = $urandom_range(1, 3);
                for (i = 0; i < k; i++)
                    put_byte(INTRO_SEQ[i]);
                case ($urandom_range(0, 2))
                    0:       put_byte(BACKSPACE);
                    1:       put_tick();
                    default: ;
                endcase
                b = 8'($urandom_range(0, 255));
                if (k == 3 && b == INTRO_SEQ[3])
                    b = 8'h00;
                put_byte(b);
            end
            default: put_byte(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic put_traffic(input int n);
        int target;
        target = queued_items + n;
        while (queued_items < target)
        begin
            if ($urandom_range(0, 9) < 7)
                put_frame(1'b0);
            else
                repeat ($urandom_range(1, 6))
                    put_noise();
        end
    endtask

    task automatic wait_idle();
        while (rx_stream.size() != 0 || s_tvalid || deframed_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [24:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_ENABLE:
            begin
                regs.enable = val[0];
                drop_frame();
            end
            REG_COMMAND_LIMIT: regs.command_limit = val[7:0];
            REG_MAX_LENGTH:    regs.max_length    = val;
            REG_TIMEOUT_TICKS: regs.timeout_ticks = val[15:0];
            REG_MIN_PROGRESS:  regs.min_progress  = val[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_settings(input int en, input int lim, input int maxl,
                                 input int tmo, input int prog);
        write_reg(REG_ENABLE, 25'(en));
        write_reg(REG_COMMAND_LIMIT, 25'(lim));
        write_reg(REG_MAX_LENGTH, 25'(maxl));
        write_reg(REG_TIMEOUT_TICKS, 25'(tmo));
        write_reg(REG_MIN_PROGRESS, 25'(prog));
        gen_lim = lim;
        gen_max = maxl;
        gen_tmo = tmo;
    endtask

    initial
    begin : sequencer_p
        int script [20];
        regs = '{enable: 1'b0, command_limit: 8'd16, max_length: 25'd1048575,
                 timeout_ticks: 16'd2000, min_progress: 16'd50};
        drop_frame();
        gen_lim = 16;
        gen_max = 1048575;
        gen_tmo = 2000;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        put_byte(8'hFF);
        put_byte(8'h00);
        put_tick();
        put_byte(ESC_BYTE);
        wait_idle();
        write_reg(REG_ENABLE, 25'd1);

        // stray backspace, backspaced intro, restart on ESC, mismatch,
        // backspace as a command, empty body with a good trailer
        script = '{8'h08, -1, 8'h1B, 8'h5B, 8'h08, 8'h08, 8'h1B, 8'h1B, -1, 8'h41,
                   8'h1B, 8'h5B, 8'h57, 8'h5D, 8'h08, 8'h00, 8'h00, 8'h00, 8'h42, 8'h53};
        foreach (script[i])
        begin
            if (script[i] < 0)
                put_tick();
            else
                put_byte(8'(script[i]));
        end
        put_byte(8'h54);
        put_byte(8'h2E);
        wait_idle();

        load_settings(1, 16, 20, 6, 3);
        put_traffic(60);
        wait_idle();
        put_traffic(60);
        wait_idle();

        load_settings(1, 255, 5, 1, 0);
        put_traffic(110);
        wait_idle();

        load_settings(1, 1, 16777219, 3, 65535);
        put_frame(1'b1);
        put_traffic(110);
        wait_idle();

        load_settings(0, 200, 1000, 4, 10);
        put_traffic(40);
        wait_idle();

        no_idle = 1'b1;
        load_settings(1, 64, 100, 65535, 50);
        put_traffic(110);
        wait_idle();
        repeat (8) @(posedge clk);

        if (mismatches == 0 && deframed_q.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
